[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, reset included
`define L2RA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

// property checked outside reset
`define L2RA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[src/l2ra_pkg.sv]
// types, constants and helpers shared by the acl reassembly block
`default_nettype none

package l2ra_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam int MTU_W   = 10;
   localparam logic [MTU_W-1:0] MTU_RESET = 10'd247;

   localparam logic [7:0] H4_ACL   = 8'h02;
   localparam logic [1:0] PB_FIRST = 2'd2;
   localparam logic [1:0] PB_CONT  = 2'd1;

   localparam logic [3:0] POS_TYPE     = 4'd0;
   localparam logic [3:0] POS_HANDLE_L = 4'd1;
   localparam logic [3:0] POS_HANDLE_H = 4'd2;
   localparam logic [3:0] POS_ACL_L    = 4'd3;
   localparam logic [3:0] POS_ACL_H    = 4'd4;
   localparam logic [3:0] POS_LEN_L    = 4'd5;
   localparam logic [3:0] POS_LEN_H    = 4'd6;
   localparam logic [3:0] POS_CID_L    = 4'd7;
   localparam logic [3:0] POS_CID_H    = 4'd8;
   localparam logic [3:0] POS_PAYLOAD  = 4'd9;

   localparam logic [15:0] L2CAP_HDR_LEN = 16'd4;
   localparam logic [7:0]  CID_ATT       = 8'h04;
   localparam logic [7:0]  CID_SMP       = 8'h06;
   localparam logic [7:0]  HANDLE_H_MASK = 8'h0F;

   localparam logic [1:0] ROUTE_SIG     = 2'd1;
   localparam logic [1:0] ROUTE_UNKNOWN = 2'd3;

   localparam logic [4:0] HDR_LAST = 5'd8;
   localparam logic [4:0] REJ_LAST = 5'd18;

   typedef enum logic [1:0] {
      KIND_FRAME  = 2'd0,
      KIND_REJECT = 2'd1,
      KIND_ABORT  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_ABORT   = 2'd0,
      OP_HEADER  = 2'd1,
      OP_PAYLOAD = 2'd2,
      OP_REJECT  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        abort_after;
      logic        last;
      logic [7:0]  data;
      logic [1:0]  route;
      logic [7:0]  handle_low;
      logic [7:0]  handle_high;
      logic [15:0] l2cap_len;
      logic [7:0]  chan_low;
      logic [7:0]  chan_high;
   } cmd_type;

   // fixed bytes of the invalid-cid command reject
   function automatic logic [7:0] reject_const(input logic [4:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = 8'h02;
         5'd3:    b = 8'h0e;
         5'd5:    b = 8'h0a;
         5'd7:    b = 8'h05;
         5'd9:    b = 8'h01;
         5'd11:   b = 8'h06;
         5'd13:   b = 8'h02;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

[src/l2ra_if.sv]
// handshake channels of the acl reassembly block
`default_nettype none

interface l2ra_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface l2ra_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] out_kind;
   logic [1:0] out_route;
   logic       out_last;
   modport source (output valid, output out_byte, output out_kind, output out_route,
                   output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_kind, input out_route,
                   input out_last, output ready);
endinterface

interface l2ra_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] max_mtu;
   modport source (output valid, output max_mtu, input ready);
   modport sink   (input valid, input max_mtu, output ready);
endinterface

`default_nettype wire

[src/l2ra_front.sv]
// front end: h4 parser and fragment bookkeeping, one command per word that emits
`default_nettype none

module l2ra_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                req_in_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [9:0]          csr_max_mtu,
   input  logic                fifo_full,
   output logic                push,
   output l2ra_pkg::cmd_type   push_cmd
);
   import l2ra_pkg::*;

   logic [MTU_W-1:0] mtu_ff;
   logic             acl_ff, acl_in;
   logic [3:0]       pos_ff, pos_in, pos_next;
   logic [7:0]       acl_lo_ff, acl_lo_in;
   logic [15:0]      frag_ff, frag_in;
   logic [1:0]       pb_ff, pb_in;
   logic [7:0]       hl_ff, hl_in, hh_ff, hh_in;
   logic [15:0]      l2len_ff, l2len_in;
   logic [7:0]       chl_ff, chl_in, chh_ff, chh_in;
   logic [15:0]      sdu_ff, sdu_in;
   logic             open_ff, open_in;
   logic [1:0]       route_ff, route_in;

   logic             accept;
   logic             main_v, last_flag, tail_emit;
   op_type           main_op;
   logic [15:0]      acl_len;

   assign req_ready = !fifo_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign acl_len   = {req_in_byte, acl_lo_ff};

   always_comb begin
      acl_in    = acl_ff;
      acl_lo_in = acl_lo_ff;
      frag_in   = frag_ff;
      pb_in     = pb_ff;
      hl_in     = hl_ff;
      hh_in     = hh_ff;
      l2len_in  = l2len_ff;
      chl_in    = chl_ff;
      chh_in    = chh_ff;
      sdu_in    = sdu_ff;
      open_in   = open_ff;
      route_in  = route_ff;
      main_v    = 1'b0;
      main_op   = OP_PAYLOAD;
      last_flag = 1'b0;
      tail_emit = 1'b0;
      pos_next  = (pos_ff < POS_PAYLOAD) ? 4'(pos_ff + 4'd1) : POS_PAYLOAD;

      if (pos_ff == POS_TYPE) begin
         acl_in = (req_in_byte == H4_ACL);
      end else if (acl_ff) begin
         case (pos_ff)
            POS_HANDLE_L: hl_in = req_in_byte;
            POS_HANDLE_H: begin
               hh_in = req_in_byte;
               pb_in = req_in_byte[5:4];
            end
            POS_ACL_L: acl_lo_in = req_in_byte;
            POS_ACL_H: begin
               if (pb_ff == PB_FIRST) begin
                  // a new first fragment closes whatever is open
                  open_in = 1'b0;
                  if (open_ff && route_ff != ROUTE_UNKNOWN) begin
                     main_v  = 1'b1;
                     main_op = OP_ABORT;
                  end
                  if (acl_len < L2CAP_HDR_LEN ||
                      {1'b0, acl_len} > (17'(mtu_ff) + 17'(L2CAP_HDR_LEN)))
                     acl_in = 1'b0;
                  else
                     frag_in = 16'(acl_len - L2CAP_HDR_LEN);
               end else if (pb_ff == PB_CONT) begin
                  if (!open_ff) begin
                     acl_in = 1'b0;
                  end else if (acl_len > sdu_ff) begin
                     open_in = 1'b0;
                     acl_in  = 1'b0;
                     if (route_ff != ROUTE_UNKNOWN) begin
                        main_v  = 1'b1;
                        main_op = OP_ABORT;
                     end
                  end else begin
                     frag_in  = acl_len;
                     pos_next = POS_PAYLOAD;
                  end
               end else begin
                  acl_in = 1'b0;
               end
            end
            POS_LEN_L: l2len_in = {8'h00, req_in_byte};
            POS_LEN_H: begin
               l2len_in = {req_in_byte, l2len_ff[7:0]};
               if (frag_ff > l2len_in)
                  acl_in = 1'b0;
            end
            POS_CID_L: chl_in = req_in_byte;
            POS_CID_H: begin
               chh_in = req_in_byte;
               if (req_in_byte == 8'h00 && chl_ff inside {[CID_ATT:CID_SMP]})
                  route_in = 2'(chl_ff - CID_ATT);
               else
                  route_in = ROUTE_UNKNOWN;
               sdu_in  = l2len_ff;
               open_in = 1'b1;
               if (route_in != ROUTE_UNKNOWN) begin
                  main_v    = 1'b1;
                  main_op   = OP_HEADER;
                  last_flag = (l2len_ff == 16'd0);
               end
               if (l2len_ff == 16'd0) begin
                  open_in = 1'b0;
                  if (route_in == ROUTE_UNKNOWN) begin
                     main_v  = 1'b1;
                     main_op = OP_REJECT;
                  end
               end
            end
            default: begin
               if (open_ff && frag_ff != 16'd0) begin
                  frag_in = 16'(frag_ff - 16'd1);
                  sdu_in  = 16'(sdu_ff - 16'd1);
                  if (route_ff != ROUTE_UNKNOWN) begin
                     main_v    = 1'b1;
                     main_op   = OP_PAYLOAD;
                     last_flag = (sdu_in == 16'd0);
                  end
                  if (sdu_in == 16'd0) begin
                     open_in = 1'b0;
                     if (route_ff == ROUTE_UNKNOWN) begin
                        main_v  = 1'b1;
                        main_op = OP_REJECT;
                     end
                  end
               end
            end
         endcase
      end

      // packet ends before the fragment is complete
      if (req_in_last && acl_in && pos_next == POS_PAYLOAD && open_in && frag_in != 16'd0) begin
         open_in   = 1'b0;
         tail_emit = (route_in != ROUTE_UNKNOWN);
      end
      pos_in = req_in_last ? POS_TYPE : pos_next;
   end

   assign push                 = accept && (main_v || tail_emit);
   assign push_cmd.op          = main_v ? main_op : OP_ABORT;
   assign push_cmd.abort_after = main_v && tail_emit;
   assign push_cmd.last        = last_flag;
   assign push_cmd.data        = req_in_byte;
   assign push_cmd.route       = route_in;
   assign push_cmd.handle_low  = hl_in;
   assign push_cmd.handle_high = hh_in;
   assign push_cmd.l2cap_len   = l2len_in;
   assign push_cmd.chan_low    = chl_in;
   assign push_cmd.chan_high   = chh_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff   <= MTU_RESET;
         acl_ff   <= 1'b0;
         pos_ff   <= POS_TYPE;
         frag_ff  <= 16'd0;
         pb_ff    <= 2'd0;
         l2len_ff <= 16'd0;
         sdu_ff   <= 16'd0;
         open_ff  <= 1'b0;
         route_ff <= 2'd0;
      end else begin
         if (csr_valid && csr_ready)
            mtu_ff <= csr_max_mtu;
         if (accept) begin
            acl_ff   <= acl_in;
            pos_ff   <= pos_in;
            frag_ff  <= frag_in;
            pb_ff    <= pb_in;
            l2len_ff <= l2len_in;
            sdu_ff   <= sdu_in;
            open_ff  <= open_in;
            route_ff <= route_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acl_lo_ff <= acl_lo_in;
         hl_ff     <= hl_in;
         hh_ff     <= hh_in;
         chl_ff    <= chl_in;
         chh_ff    <= chh_in;
      end
   end

endmodule

`default_nettype wire

[src/l2ra_fifo.sv]
// short command queue between parser and emitter
`default_nettype none

module l2ra_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  l2ra_pkg::cmd_type push_cmd,
   input  logic              pop,
   output l2ra_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);
   import l2ra_pkg::*;

   cmd_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_CW-1:0] cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == FIFO_CW'(FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? FIFO_AW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? FIFO_AW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop)
         cnt_in = FIFO_CW'(cnt_ff + 1'b1);
      else if (do_pop && !do_push)
         cnt_in = FIFO_CW'(cnt_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

[src/l2ra_back.sv]
// back end: expands queued commands into output words
`default_nettype none

module l2ra_back (
   input  logic              clock,
   input  logic              reset,
   input  l2ra_pkg::cmd_type head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic [1:0]        rsp_out_kind,
   output logic [1:0]        rsp_out_route,
   output logic              rsp_out_last
);
   import l2ra_pkg::*;

   typedef enum logic [1:0] {
      ST_MAIN  = 2'b01,
      ST_ABORT = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  route_ff, route_in;
   logic        last_ff, last_in;

   logic        step, done;
   logic [15:0] plen;
   logic [7:0]  hdr_byte, rej_byte;

   assign step = !empty && (!valid_ff || rsp_ready);
   assign plen = 16'(head.l2cap_len + L2CAP_HDR_LEN);

   always_comb begin
      case (idx_ff)
         5'd0:    hdr_byte = H4_ACL;
         5'd1:    hdr_byte = head.handle_low;
         5'd2:    hdr_byte = head.handle_high;
         5'd3:    hdr_byte = plen[7:0];
         5'd4:    hdr_byte = plen[15:8];
         5'd5:    hdr_byte = head.l2cap_len[7:0];
         5'd6:    hdr_byte = head.l2cap_len[15:8];
         5'd7:    hdr_byte = head.chan_low;
         5'd8:    hdr_byte = head.chan_high;
         default: hdr_byte = 8'h00;
      endcase
   end

   always_comb begin
      case (idx_ff)
         5'd1:    rej_byte = head.handle_low;
         5'd2:    rej_byte = head.handle_high & HANDLE_H_MASK;
         5'd15:   rej_byte = head.chan_low;
         5'd16:   rej_byte = head.chan_high;
         default: rej_byte = reject_const(idx_ff);
      endcase
   end

   always_comb begin
      byte_in  = 8'h00;
      kind_in  = KIND_ABORT;
      route_in = head.route;
      last_in  = 1'b1;
      done     = 1'b1;
      if (state_ff == ST_MAIN) begin
         case (head.op)
            OP_HEADER: begin
               byte_in = hdr_byte;
               kind_in = KIND_FRAME;
               last_in = (idx_ff == HDR_LAST) && head.last;
               done    = (idx_ff == HDR_LAST);
            end
            OP_PAYLOAD: begin
               byte_in = head.data;
               kind_in = KIND_FRAME;
               last_in = head.last;
            end
            OP_REJECT: begin
               byte_in  = rej_byte;
               kind_in  = KIND_REJECT;
               route_in = ROUTE_SIG;
               last_in  = (idx_ff == REJ_LAST);
               done     = (idx_ff == REJ_LAST);
            end
            default: begin
               byte_in = 8'h00;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      valid_in = valid_ff && !rsp_ready;
      if (step) begin
         valid_in = 1'b1;
         case (state_ff)
            ST_MAIN: begin
               if (done) begin
                  idx_in = 5'd0;
                  if (head.abort_after)
                     state_in = ST_ABORT;
                  else
                     pop = 1'b1;
               end else begin
                  idx_in = 5'(idx_ff + 5'd1);
               end
            end
            ST_ABORT: begin
               state_in = ST_MAIN;
               pop      = 1'b1;
            end
            default: begin
               state_in = ST_MAIN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MAIN;
         idx_ff   <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         byte_ff  <= byte_in;
         kind_ff  <= kind_in;
         route_ff <= route_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_out_kind  = kind_ff;
   assign rsp_out_route = route_ff;
   assign rsp_out_last  = last_ff;

endmodule

`default_nettype wire

[src/l2cap_acl_reassembly.sv]
// top level of the l2cap acl reassembly block
`default_nettype none

// Takes an H4 byte stream one word per cycle while the queue has room and sends out reassembled
// L2CAP frames, abort markers and invalid-cid command rejects. The parser decides each input word
// as it is accepted and hands a command to a four-entry queue; the emitter turns each command
// into words (payload 1, frame header 9, command reject 19, abort 1, plus 1 for an abort that
// follows a truncated fragment) into an output register, one word per cycle while the output is
// ready. Payload bytes pass through a queue entry and the output register; input stalls only
// while the queue is full, which a header or reject burst can cause when the output side is slow
// or busy with a long burst. max_mtu is written through the csr channel, which is always ready.

module l2cap_acl_reassembly (
   input  wire            clock,
   input  wire            reset,
   l2ra_req_if.sink       req_chan,
   l2ra_rsp_if.source     rsp_chan,
   l2ra_csr_if.sink       csr_chan
);
   import l2ra_pkg::*;

   logic    push, pop, full, empty;
   cmd_type push_cmd, head;
   logic    req_ready, csr_ready;

   l2ra_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_ready),
      .req_in_byte (req_chan.in_byte),
      .req_in_last (req_chan.in_last),
      .csr_valid   (csr_chan.valid),
      .csr_ready   (csr_ready),
      .csr_max_mtu (csr_chan.max_mtu),
      .fifo_full   (full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   l2ra_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   l2ra_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_out_byte  (rsp_chan.out_byte),
      .rsp_out_kind  (rsp_chan.out_kind),
      .rsp_out_route (rsp_chan.out_route),
      .rsp_out_last  (rsp_chan.out_last)
   );

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = csr_ready;

endmodule

`default_nettype wire

[src/l2ra_checker.sv]
// port-level checks for the acl reassembly block, with bind
`default_nettype none
`include "assert_macros.svh"

module l2ra_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] out_byte,
   input wire [1:0] out_kind,
   input wire [1:0] out_route,
   input wire       out_last
);
   import l2ra_pkg::*;

   `L2RA_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "word after reset")
   `L2RA_ASSERT(a_abort_shape, clock, reset, rsp_valid && out_kind == KIND_ABORT |-> out_byte == 8'h00 && out_last, "malformed abort word")
   `L2RA_ASSERT(a_reject_route, clock, reset, rsp_valid && out_kind == KIND_REJECT |-> out_route == ROUTE_SIG, "reject word off signalling route")
   `L2RA_ASSERT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(out_last), "stalled word changed")

endmodule

bind l2cap_acl_reassembly l2ra_checker u_l2ra_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_byte  (rsp_chan.out_byte),
   .out_kind  (rsp_chan.out_kind),
   .out_route (rsp_chan.out_route),
   .out_last  (rsp_chan.out_last)
);

`default_nettype wire

[test/tb.sv]
// testbench for the l2cap acl reassembly block: h4 stream stimulus, frame and reject checking
`timescale 1ns / 1ps

module tb;
   import l2ra_pkg::*;

   localparam int          HALF_PERIOD = 5;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          IDLE_TAIL   = 40;
   localparam int          PHASE_WORDS = 42;
   localparam int          SHOW_LIMIT  = 10;
   localparam int          MAX_WAIT    = 16;
   localparam logic [9:0]  MTU_LOW     = 10'd23;
   localparam logic [9:0]  MTU_HIGH    = 10'd517;
   localparam logic [7:0]  H4_NONE     = 8'h00;
   localparam logic [7:0]  H4_EVENT    = 8'h04;
   localparam logic [1:0]  PB_FIRST_NF = 2'd0;
   localparam logic [1:0]  PB_AUTO     = 2'd3;
   localparam logic [15:0] CH_ATT      = 16'h0004;
   localparam logic [15:0] CH_SIG      = 16'h0005;
   localparam logic [15:0] CH_SMP      = 16'h0006;
   localparam int          REJ_WORDS   = 19;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic [1:0] route;
      logic       last;
   } out_word_t;

   typedef logic [7:0] byte_q_t [$];

   class acl_scoreboard;
      logic [9:0]  mtu;
      logic [7:0]  pkt_type, hnd_lo, hnd_hi, cid_lo, cid_hi;
      logic [3:0]  hdr_pos;
      logic [15:0] acl_len, frag_left, l2_len, sdu_left;
      logic [1:0]  pb_flag, route;
      bit          frame_open;
      out_word_t   frame_words_due[$];
      int          errors;

      function new();
         mtu        = MTU_RESET;
         pkt_type   = H4_NONE;
         hnd_lo     = '0;
         hnd_hi     = '0;
         cid_lo     = '0;
         cid_hi     = '0;
         hdr_pos    = POS_TYPE;
         acl_len    = '0;
         frag_left  = '0;
         l2_len     = '0;
         sdu_left   = '0;
         pb_flag    = '0;
         route      = '0;
         frame_open = 0;
         errors     = 0;
      endfunction

      function int pending();
         return frame_words_due.size();
      endfunction

      function void add_due(logic [7:0] data, kind_type kind, logic [1:0] rt, logic last);
         out_word_t w;
         w.data  = data;
         w.kind  = kind;
         w.route = rt;
         w.last  = last;
         frame_words_due.push_back(w);
      endfunction

      function void abort_open();
         if (frame_open) begin
            frame_open = 0;
            if (route != ROUTE_UNKNOWN) add_due(8'h00, KIND_ABORT, route, 1'b1);
         end
      endfunction

      // invalid cid command reject sent back on the signalling channel
      function logic [7:0] reject_byte(int i);
         logic [7:0] b;
         case (i)
            0:       b = H4_ACL;
            1:       b = hnd_lo;
            2:       b = hnd_hi & HANDLE_H_MASK;
            3:       b = 8'h0e;
            5:       b = 8'h0a;
            7:       b = 8'h05;
            9:       b = 8'h01;
            11:      b = 8'h06;
            13:      b = 8'h02;
            15:      b = cid_lo;
            16:      b = cid_hi;
            default: b = 8'h00;
         endcase
         return b;
      endfunction

      function void complete_frame();
         frame_open = 0;
         if (route == ROUTE_UNKNOWN) begin
            for (int i = 0; i < REJ_WORDS; i++)
               add_due(reject_byte(i), KIND_REJECT, ROUTE_SIG, i == REJ_WORDS - 1);
         end
      endfunction

      function void note_word(logic [7:0] b, logic last);
         logic [3:0]  pos, nxt;
         logic [15:0] plen;
         logic [7:0]  d;
         pos = hdr_pos;
         nxt = (pos < POS_PAYLOAD) ? pos + 4'd1 : POS_PAYLOAD;
         if (pos == POS_TYPE) begin
            pkt_type = b;
         end else if (pkt_type == H4_ACL) begin
            case (pos)
               POS_HANDLE_L: hnd_lo = b;
               POS_HANDLE_H: begin
                  hnd_hi  = b;
                  pb_flag = b[5:4];
               end
               POS_ACL_L: acl_len = {8'h00, b};
               POS_ACL_H: begin
                  acl_len[15:8] = b;
                  if (pb_flag == PB_FIRST) begin
                     abort_open();
                     if (acl_len < L2CAP_HDR_LEN || acl_len > {6'd0, mtu} + L2CAP_HDR_LEN)
                        pkt_type = H4_NONE;
                     else
                        frag_left = acl_len - L2CAP_HDR_LEN;
                  end else if (pb_flag == PB_CONT) begin
                     if (!frame_open) begin
                        pkt_type = H4_NONE;
                     end else if (acl_len > sdu_left) begin
                        abort_open();
                        pkt_type = H4_NONE;
                     end else begin
                        frag_left = acl_len;
                        nxt       = POS_PAYLOAD;
                     end
                  end else begin
                     pkt_type = H4_NONE;
                  end
               end
               POS_LEN_L: l2_len = {8'h00, b};
               POS_LEN_H: begin
                  l2_len[15:8] = b;
                  if (frag_left > l2_len) pkt_type = H4_NONE;
               end
               POS_CID_L: cid_lo = b;
               POS_CID_H: begin
                  cid_hi = b;
                  d      = cid_lo - CID_ATT;
                  if (cid_hi == 8'h00 && cid_lo >= CID_ATT && cid_lo <= CID_SMP)
                     route = d[1:0];
                  else
                     route = ROUTE_UNKNOWN;
                  sdu_left   = l2_len;
                  frame_open = 1;
                  plen       = l2_len + L2CAP_HDR_LEN;
                  if (route != ROUTE_UNKNOWN) begin
                     add_due(H4_ACL, KIND_FRAME, route, 1'b0);
                     add_due(hnd_lo, KIND_FRAME, route, 1'b0);
                     add_due(hnd_hi, KIND_FRAME, route, 1'b0);
                     add_due(plen[7:0], KIND_FRAME, route, 1'b0);
                     add_due(plen[15:8], KIND_FRAME, route, 1'b0);
                     add_due(l2_len[7:0], KIND_FRAME, route, 1'b0);
                     add_due(l2_len[15:8], KIND_FRAME, route, 1'b0);
                     add_due(cid_lo, KIND_FRAME, route, 1'b0);
                     add_due(cid_hi, KIND_FRAME, route, sdu_left == 16'd0);
                  end
                  if (sdu_left == 16'd0) complete_frame();
               end
               default: begin
                  if (frame_open && frag_left > 16'd0) begin
                     frag_left--;
                     sdu_left--;
                     if (route != ROUTE_UNKNOWN)
                        add_due(b, KIND_FRAME, route, sdu_left == 16'd0);
                     if (sdu_left == 16'd0) complete_frame();
                  end
               end
            endcase
         end
         hdr_pos = nxt;
         if (last) begin
            // packet ended while the fragment still owed payload
            if (pkt_type == H4_ACL && hdr_pos == POS_PAYLOAD && frame_open && frag_left > 16'd0)
               abort_open();
            hdr_pos = POS_TYPE;
         end
      endfunction

      function void check_word(out_word_t got);
         out_word_t want;
         if (frame_words_due.size() == 0) begin
            errors++;
            if (errors <= SHOW_LIMIT)
               $display("unexpected word: byte %02h kind %0d route %0d last %0b",
                        got.data, got.kind, got.route, got.last);
            return;
         end
         want = frame_words_due.pop_front();
         if (want.data !== got.data || want.kind !== got.kind || want.route !== got.route ||
             want.last !== got.last) begin
            errors++;
            if (errors <= SHOW_LIMIT)
               $display("word mismatch: expected byte %02h kind %0d route %0d last %0b, got byte %02h kind %0d route %0d last %0b",
                        want.data, want.kind, want.route, want.last,
                        got.data, got.kind, got.route, got.last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   always #HALF_PERIOD clock = ~clock;

   l2ra_req_if req_chan ();
   l2ra_rsp_if rsp_chan ();
   l2ra_csr_if csr_chan ();

   l2cap_acl_reassembly dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   acl_scoreboard sb;
   bit            req_calm;
   bit            rsp_calm;
   int            words_sent;
   int unsigned   cycle_count = 0;

   function automatic logic [15:0] rand_range16(int lo, int hi);
      int unsigned r;
      r = $urandom_range(hi, lo);
      return r[15:0];
   endfunction

   function automatic logic [15:0] pick_cid();
      int unsigned r;
      int unsigned t;
      r = $urandom_range(9, 0);
      t = $urandom;
      if (r < 7) return CH_ATT + rand_range16(0, 2);
      if (r == 7) return {t[7:0] | 8'h01, CID_ATT + {6'd0, t[9:8] % 2'd3}};
      return t[15:0];
   endfunction

   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(29, 0);
      if (r == 0) return {6'd0, sb.mtu};
      if (r < 4) return rand_range16(21, 64);
      return rand_range16(0, 20);
   endfunction

   task automatic push_word(input logic [7:0] b, input logic last);
      int wait_cycles;
      wait_cycles = req_calm ? 0 : $urandom_range(MAX_WAIT, 0);
      if ($urandom_range(31, 0) == 0) req_calm = !req_calm;
      if (wait_cycles > 0) begin
         req_chan.valid <= 1'b0;
         repeat (wait_cycles) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.in_last <= last;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_word(b, last);
      words_sent++;
   endtask

   task automatic settle_idle();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic csr_write(input logic [9:0] value);
      settle_idle();
      csr_chan.valid   <= 1'b1;
      csr_chan.max_mtu <= value;
      do @(posedge clock); while (!csr_chan.ready);
      sb.mtu = value;
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send_packet(input byte_q_t pkt);
      foreach (pkt[i]) push_word(pkt[i], i == pkt.size() - 1);
   endtask

   task automatic add_random(inout byte_q_t q, input int n);
      int unsigned t;
      repeat (n) begin
         t = $urandom;
         q.push_back(t[7:0]);
      end
   endtask

   task automatic make_head(output byte_q_t q, input logic [15:0] l2len, input logic [15:0] cid);
      q.delete();
      q.push_back(l2len[7:0]);
      q.push_back(l2len[15:8]);
      q.push_back(cid[7:0]);
      q.push_back(cid[15:8]);
   endtask

   task automatic send_acl(input logic [11:0] hnd, input logic [1:0] pb,
                           input logic [15:0] acl, input byte_q_t body);
      byte_q_t     pkt;
      int unsigned t;
      t = $urandom;
      pkt.push_back(H4_ACL);
      pkt.push_back(hnd[7:0]);
      pkt.push_back({t[1:0], pb, hnd[11:8]});
      pkt.push_back(acl[7:0]);
      pkt.push_back(acl[15:8]);
      foreach (body[i]) pkt.push_back(body[i]);
      send_packet(pkt);
   endtask

   task automatic send_first(input logic [11:0] hnd, input logic [15:0] l2len,
                             input logic [15:0] cid, input int n_pay, input int surplus);
      byte_q_t body;
      int      t;
      make_head(body, l2len, cid);
      add_random(body, n_pay + surplus);
      t = n_pay + 4;
      send_acl(hnd, PB_FIRST, t[15:0], body);
   endtask

   task automatic send_cont(input logic [11:0] hnd, input int n_body, input logic [15:0] acl);
      byte_q_t body;
      add_random(body, n_body);
      send_acl(hnd, PB_CONT, acl, body);
   endtask

   // packets that must leave an open frame untouched
   task automatic send_stray(input logic [11:0] hnd);
      byte_q_t body;
      int      n;
      n = $urandom_range(4, 0);
      add_random(body, n);
      if ($urandom_range(2, 0) == 0) begin
         push_word(H4_EVENT, 1'b0);
         send_packet(body.size() > 0 ? body : '{8'h0e});
      end else begin
         send_acl(hnd, $urandom_range(1, 0) ? PB_FIRST_NF : PB_AUTO, n[15:0], body);
      end
   endtask

   task automatic send_frame(input logic [11:0] hnd, input logic [15:0] cid,
                             input logic [15:0] l2len);
      int cap, first_n, left, n;
      cap     = (l2len < {6'd0, sb.mtu}) ? int'(l2len) : int'(sb.mtu);
      first_n = $urandom_range(cap, 0);
      send_first(hnd, l2len, cid, first_n, 0);
      left = int'(l2len) - first_n;
      while (left > 0) begin
         if ($urandom_range(9, 0) == 0) send_stray(hnd);
         n = $urandom_range((left > 32) ? 32 : left, 1);
         send_cont(hnd, n, n[15:0]);
         left -= n;
      end
   endtask

   task automatic broken_frame(input logic [11:0] hnd);
      int      l2, first_n, rem, acl, k;
      byte_q_t body;
      l2      = $urandom_range(20, 2);
      first_n = $urandom_range(l2 - 1, 0);
      rem     = l2 - first_n;
      send_first(hnd, l2[15:0], pick_cid(), first_n, 0);
      case ($urandom_range(6, 0))
         0: begin
            // fragment cut short by the end of its packet
            acl = $urandom_range(rem, 1);
            send_cont(hnd, $urandom_range(acl - 1, 0), acl[15:0]);
         end
         1: begin
            acl = rem + $urandom_range(4, 1);
            send_cont(hnd, acl, acl[15:0]);
         end
         2: send_frame(hnd, pick_cid(), pick_len());
         3: send_cont(hnd, rem + $urandom_range(5, 1), rem[15:0]);
         4: begin
            // first fragment carrying more than its frame length
            k = $urandom_range(8, 0);
            make_head(body, k[15:0], pick_cid());
            acl = k + 4 + $urandom_range(3, 1);
            add_random(body, acl - 4);
            send_acl(hnd, PB_FIRST, acl[15:0], body);
         end
         5: begin
            acl = $urandom_range(3, 0);
            add_random(body, acl);
            send_acl(hnd, PB_FIRST, acl[15:0], body);
         end
         default: begin
            make_head(body, pick_len(), pick_cid());
            add_random(body, 2);
            acl = int'(sb.mtu) + 5 + $urandom_range(3, 0);
            send_acl(hnd, PB_FIRST, acl[15:0], body);
         end
      endcase
   endtask

   task automatic random_traffic();
      int          r, n;
      int unsigned t;
      logic [11:0] hnd;
      byte_q_t     body;
      t   = $urandom;
      hnd = t[11:0];
      r   = $urandom_range(99, 0);
      if (r < 60) begin
         send_frame(hnd, pick_cid(), pick_len());
      end else if (r < 78) begin
         broken_frame(hnd);
      end else if (r < 86) begin
         t = $urandom;
         body.push_back(t[7:0] == H4_ACL ? H4_EVENT : t[7:0]);
         add_random(body, $urandom_range(7, 0));
         send_packet(body);
      end else if (r < 93) begin
         add_random(body, $urandom_range(8, 0));
         t = $urandom;
         send_acl(hnd, t[1:0], t[31:16], body);
      end else begin
         // loose bytes with stray packet ends, often starting like an acl packet
         n = $urandom_range(12, 1);
         for (int i = 0; i < n; i++) begin
            t = $urandom;
            push_word((i == 0 && t[10]) ? H4_ACL : t[7:0], i == n - 1 || t[9:8] == 2'd0);
         end
      end
   endtask

   initial begin
      int          ph, start;
      int unsigned t;
      logic [9:0]  value;
      byte_q_t     body;
      sb = new();
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.in_byte <= 8'h00;
      req_chan.in_last <= 1'b0;
      csr_chan.valid   <= 1'b0;
      csr_chan.max_mtu <= MTU_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      csr_write(MTU_LOW);

      send_first(12'h000, 16'd3, CH_ATT, 3, 0);
      send_first(12'hFFF, 16'd5, CH_SIG, 2, 0);
      send_cont(12'hFFF, 3, 16'd3);
      send_first(12'h123, 16'd0, CH_SMP, 0, 0);
      send_first(12'h456, 16'd2, 16'h0104, 2, 0);
      push_word(H4_EVENT, 1'b0);
      push_word(8'h0e, 1'b0);
      push_word(8'hff, 1'b1);
      send_cont(12'h001, 2, 16'd2);
      // flags 0 and 3 between fragments of an open frame
      send_first(12'h7AC, 16'd4, CH_ATT, 1, 0);
      add_random(body, 1);
      send_acl(12'h7AC, PB_FIRST_NF, 16'd1, body);
      send_acl(12'h7AC, PB_AUTO, 16'd1, body);
      send_cont(12'h7AC, 3, 16'd3);
      send_first(12'h0A5, 16'd24, CH_ATT, 24, 0);
      send_first(12'h0A5, 16'd23, CH_SIG, 23, 0);
      body.delete();
      add_random(body, 3);
      send_acl(12'h35C, PB_FIRST, 16'd3, body);
      make_head(body, 16'd1, CH_ATT);
      add_random(body, 2);
      send_acl(12'h35C, PB_FIRST, 16'd6, body);
      send_first(12'h811, 16'd6, CH_SIG, 2, 0);
      send_first(12'h812, 16'd1, CH_ATT, 1, 0);
      send_first(12'h900, 16'd4, CH_SMP, 1, 0);
      send_cont(12'h900, 4, 16'd4);
      send_first(12'h901, 16'd5, CH_ATT, 1, 0);
      send_cont(12'h901, 1, 16'd3);
      send_first(12'h902, 16'd2, CH_SIG, 2, 3);
      send_first(12'h903, 16'd3, 16'h0007, 1, 0);
      send_first(12'h904, 16'd0, CH_ATT, 0, 0);
      send_first(12'h905, 16'hFFFE, CH_ATT, 2, 0);
      send_first(12'h906, 16'd0, 16'h0003, 0, 0);
      push_word(H4_ACL, 1'b1);
      push_word(H4_NONE, 1'b1);
      push_word(H4_ACL, 1'b0);
      push_word(8'h11, 1'b0);
      push_word(8'h20, 1'b1);

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       value = MTU_HIGH;
            1:       value = MTU_LOW;
            default: begin
               t     = $urandom_range(MTU_HIGH - 1, MTU_LOW + 1);
               value = t[9:0];
            end
         endcase
         csr_write(value);
         start = words_sent;
         while (words_sent - start < PHASE_WORDS) random_traffic();
      end

      settle_idle();
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      int        stall;
      out_word_t got;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(MAX_WAIT, 0);
         if ($urandom_range(31, 0) == 0) rsp_calm = !rsp_calm;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.data  = rsp_chan.out_byte;
         got.kind  = kind_type'(rsp_chan.out_kind);
         got.route = rsp_chan.out_route;
         got.last  = rsp_chan.out_last;
         sb.check_word(got);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
